[hw/rtl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants for the JSON string unescape / UTF-8 unit.
// ----------------------------------------------------------------------------
package jsu_pkg;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       run_last;
    } out_item_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [15:0] CP_2BYTE   = 16'h0080;
    localparam logic [15:0] CP_3BYTE   = 16'h0800;

endpackage

[hw/rtl/jsu_stream_if.sv]
// ----------------------------------------------------------------------------
// jsu_stream_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface jsu_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

[hw/rtl/json_string_unescape_utf8_unit.sv]
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// Unescapes a JSON string one source byte at a time and emits UTF-8 bytes
// plus end-of-string and missing-quote results.
// ----------------------------------------------------------------------------
//  channel  dir  payload                        item
//  rx       in   in_byte[8], final_byte[1]      one source byte
//  tx       out  out_byte[8], kind[2], run_last one result byte / marker
//
//  Each source byte yields 0 to 4 results; one result leaves per cycle
//  while tx.ready is high. One input byte is taken per cycle while it
//  yields at most one result and tx does not stall; an item with several
//  results (UTF-8 expansion, data plus end marker) holds the next item back
//  until its last result has left. A 2-entry input buffer gives a registered
//  rx.ready; results leave from a registered result bundle.
//  Reset puts the decoder in the wait-for-opening-quote state.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit
    import jsu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    jsu_stream_if.sink          rx,
    jsu_stream_if.source        tx
);

    typedef enum logic [1:0] {
        MODE_WAIT = 2'd0,
        MODE_STR  = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_HEX  = 2'd3
    } mode_t;

    localparam logic [1:0] FIFO_FULL = 2'd2;

    // input buffer
    in_item_t    fifo_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fifo_cnt_reg, fifo_cnt_next;

    // decoder state
    mode_t       mode_reg, mode_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [15:0] cp_reg, cp_next;

    // result bundle
    logic [7:0]  slot_byte_reg [4];
    kind_t       slot_kind_reg [4];
    logic [7:0]  slot_byte_next [4];
    kind_t       slot_kind_next [4];
    logic [2:0]  res_cnt_reg, res_cnt_next;
    logic [1:0]  idx_reg, idx_next;

    logic        push, pop, tx_fire, bundle_free, at_last;
    logic [1:0]  last_idx;
    in_item_t    head;

    // decode
    logic [7:0]  dat_b [3];
    logic [1:0]  dat_n;
    logic        first_err;
    logic        end_flag;
    logic [2:0]  total;
    logic [15:0] cp_shift;
    logic [15:0] utf_cp;
    logic        use_utf;
    logic [7:0]  c;
    logic        fin;

    function automatic logic [3:0] hex_value(input logic [7:0] h);
        logic [3:0] v;
        v = 4'd0;
        if (h inside {[8'h30:8'h39]})
            v = 4'(h - 8'h30);
        else if (h inside {[8'h61:8'h66]})
            v = 4'(h - 8'h57);
        else if (h inside {[8'h41:8'h46]})
            v = 4'(h - 8'h37);
        return v;
    endfunction

    function automatic logic [7:0] escape_map(input logic [7:0] e);
        logic [7:0] m;
        case (e)
            CH_N:    m = CH_LF;
            CH_R:    m = CH_CR;
            CH_T:    m = CH_TAB;
            default: m = e;
        endcase
        return m;
    endfunction

    assign head        = fifo_reg[rd_ptr_reg];
    assign c           = head.in_byte;
    assign fin         = head.final_byte;
    assign last_idx    = 2'(res_cnt_reg - 3'd1);
    assign at_last     = (idx_reg == last_idx);
    assign tx_fire     = tx.valid && tx.ready;
    assign bundle_free = (res_cnt_reg == 3'd0) || (tx_fire && at_last);
    assign pop         = (fifo_cnt_reg != 2'd0) && bundle_free;
    assign push        = rx.valid && rx.ready;

    assign rx.ready         = (fifo_cnt_reg != FIFO_FULL);
    assign tx.valid         = (res_cnt_reg != 3'd0);
    assign tx.data.out_byte = slot_byte_reg[idx_reg];
    assign tx.data.kind     = slot_kind_reg[idx_reg];
    assign tx.data.run_last = at_last;

    always_comb
    begin
        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        cp_next      = cp_reg;
        dat_n        = 2'd0;
        first_err    = 1'b0;
        end_flag     = 1'b0;
        use_utf      = 1'b0;
        utf_cp       = 16'd0;
        dat_b[0]     = 8'd0;
        dat_b[1]     = 8'd0;
        dat_b[2]     = 8'd0;
        cp_shift     = {cp_reg[11:0], hex_value(c)};

        case (mode_reg)
            MODE_WAIT:
            begin
                if (c == CH_QUOTE)
                begin
                    mode_next = MODE_STR;
                    end_flag  = fin;
                end
                else
                begin
                    dat_n     = 2'd1;
                    first_err = 1'b1;
                end
            end
            MODE_STR:
            begin
                if (c == CH_QUOTE)
                    end_flag = 1'b1;
                else if (c == CH_BSLASH)
                begin
                    mode_next = MODE_ESC;
                    end_flag  = fin;
                end
                else
                begin
                    dat_n    = 2'd1;
                    dat_b[0] = c;
                    end_flag = fin;
                end
            end
            MODE_ESC:
            begin
                if (c == CH_U)
                begin
                    if (fin)
                    begin
                        use_utf  = 1'b1;
                        end_flag = 1'b1;
                    end
                    else
                    begin
                        mode_next    = MODE_HEX;
                        hex_cnt_next = 2'd0;
                        cp_next      = 16'd0;
                    end
                end
                else
                begin
                    dat_n     = 2'd1;
                    dat_b[0]  = escape_map(c);
                    mode_next = MODE_STR;
                    end_flag  = fin;
                end
            end
            default:
            begin
                if (hex_cnt_reg == 2'd3 || fin)
                begin
                    use_utf      = 1'b1;
                    utf_cp       = cp_shift;
                    hex_cnt_next = 2'd0;
                    cp_next      = 16'd0;
                    mode_next    = MODE_STR;
                    end_flag     = fin;
                end
                else
                begin
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                    cp_next      = cp_shift;
                end
            end
        endcase

        if (use_utf)
        begin
            if (utf_cp < CP_2BYTE)
            begin
                dat_n    = 2'd1;
                dat_b[0] = utf_cp[7:0];
            end
            else if (utf_cp < CP_3BYTE)
            begin
                dat_n    = 2'd2;
                dat_b[0] = UTF8_LEAD2 | {3'd0, utf_cp[10:6]};
                dat_b[1] = UTF8_CONT | {2'd0, utf_cp[5:0]};
            end
            else
            begin
                dat_n    = 2'd3;
                dat_b[0] = UTF8_LEAD3 | {4'd0, utf_cp[15:12]};
                dat_b[1] = UTF8_CONT | {2'd0, utf_cp[11:6]};
                dat_b[2] = UTF8_CONT | {2'd0, utf_cp[5:0]};
            end
        end

        if (end_flag)
        begin
            mode_next    = MODE_WAIT;
            hex_cnt_next = 2'd0;
            cp_next      = 16'd0;
        end

        total = {1'b0, dat_n} + {2'd0, end_flag};

        for (int i = 0; i < 4; i++)
        begin
            slot_byte_next[i] = 8'd0;
            slot_kind_next[i] = KIND_DATA;
            if (i < 3 && 2'(i) < dat_n)
            begin
                slot_byte_next[i] = dat_b[i % 3];
                if (i == 0 && first_err)
                begin
                    slot_byte_next[i] = 8'd0;
                    slot_kind_next[i] = KIND_ERR;
                end
            end
            else if (end_flag && 3'(i) == {1'b0, dat_n})
                slot_kind_next[i] = KIND_END;
        end
    end

    always_comb
    begin
        wr_ptr_next   = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next   = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fifo_cnt_next = fifo_cnt_reg + {1'b0, push} - {1'b0, pop};
        res_cnt_next  = res_cnt_reg;
        idx_next      = idx_reg;
        if (pop)
        begin
            res_cnt_next = total;
            idx_next     = 2'd0;
        end
        else if (tx_fire)
        begin
            if (at_last)
            begin
                res_cnt_next = 3'd0;
                idx_next     = 2'd0;
            end
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            fifo_cnt_reg <= 2'd0;
            mode_reg     <= MODE_WAIT;
            hex_cnt_reg  <= 2'd0;
            cp_reg       <= 16'd0;
            res_cnt_reg  <= 3'd0;
            idx_reg      <= 2'd0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            fifo_cnt_reg <= fifo_cnt_next;
            res_cnt_reg  <= res_cnt_next;
            idx_reg      <= idx_next;
            if (pop)
            begin
                mode_reg    <= mode_next;
                hex_cnt_reg <= hex_cnt_next;
                cp_reg      <= cp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= rx.data;
        if (pop)
        begin
            for (int i = 0; i < 4; i++)
            begin
                slot_byte_reg[i] <= slot_byte_next[i];
                slot_kind_reg[i] <= slot_kind_next[i];
            end
        end
    end

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= FIFO_FULL)
        else $error("input buffer overrun");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg != 3'd0 |-> {1'b0, idx_reg} < res_cnt_reg)
        else $error("result index past bundle");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        pop && end_flag |=> mode_reg == MODE_WAIT && hex_cnt_reg == 2'd0
            && cp_reg == 16'd0)
        else $error("state not cleared after end of string");

    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && tx.data.kind == KIND_ERR |-> tx.data.run_last && idx_reg == 2'd0)
        else $error("error result shares a bundle");

    a_hex_mode: assert property (@(posedge clk) disable iff (!rst_n)
        hex_cnt_reg != 2'd0 |-> mode_reg == MODE_HEX)
        else $error("hex count outside hex escape");

endmodule

[bench/jsu_unescape_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jsu_unescape_checker
// Watches the source-byte and result channels of the unescape unit, decodes
// every accepted source byte with its own JSON string / UTF-8 decoder, and
// compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module jsu_unescape_checker
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      rx_valid,
    input  logic      rx_ready,
    input  in_item_t  rx_data,
    input  logic      tx_valid,
    input  logic      tx_ready,
    input  out_item_t tx_data,
    output int        mismatches,
    output int        outstanding,
    output int        results_seen
);

    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_DIG9  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;

    typedef enum logic [1:0] {
        AWAIT_QUOTE  = 2'd0,
        IN_TEXT      = 2'd1,
        AFTER_BSLASH = 2'd2,
        IN_HEX       = 2'd3
    } parse_state_t;

    parse_state_t parse_state;
    logic [1:0]   hex_digits;
    logic [15:0]  code_acc;

    out_item_t    step_out [4];
    int           step_n;
    out_item_t    expected_results [$];

    function void emit(logic [7:0] b, kind_t k);
        step_out[step_n] = '{out_byte: b, kind: k, run_last: 1'b0};
        step_n++;
    endfunction

    function void emit_utf8(logic [15:0] cp);
        if (cp < CP_2BYTE)
        begin
            emit(cp[7:0], KIND_DATA);
        end
        else if (cp < CP_3BYTE)
        begin
            emit(UTF8_LEAD2 | {3'b000, cp[10:6]}, KIND_DATA);
            emit(UTF8_CONT | {2'b00, cp[5:0]}, KIND_DATA);
        end
        else
        begin
            emit(UTF8_LEAD3 | {4'b0000, cp[15:12]}, KIND_DATA);
            emit(UTF8_CONT | {2'b00, cp[11:6]}, KIND_DATA);
            emit(UTF8_CONT | {2'b00, cp[5:0]}, KIND_DATA);
        end
    endfunction

    // non-hex characters count as zero
    function logic [3:0] nibble_of(logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= CH_DIG0 && c <= CH_DIG9)
            v = c - CH_DIG0;
        else if (c >= CH_LOW_A && c <= CH_LOW_F)
            v = c - CH_LOW_A + 8'd10;
        else if (c >= CH_UP_A && c <= CH_UP_F)
            v = c - CH_UP_A + 8'd10;
        return v[3:0];
    endfunction

    function void decode_source_byte(in_item_t it);
        logic       done;
        logic [7:0] c;
        logic [7:0] mapped;
        c = it.in_byte;
        done = 1'b0;
        step_n = 0;
        case (parse_state)
            AWAIT_QUOTE:
            begin
                if (c == CH_QUOTE)
                begin
                    parse_state = IN_TEXT;
                    done = it.final_byte;
                end
                else
                begin
                    emit(8'h00, KIND_ERR);
                end
            end
            IN_TEXT:
            begin
                if (c == CH_QUOTE)
                begin
                    done = 1'b1;
                end
                else if (c == CH_BSLASH)
                begin
                    parse_state = AFTER_BSLASH;
                    done = it.final_byte;
                end
                else
                begin
                    emit(c, KIND_DATA);
                    done = it.final_byte;
                end
            end
            AFTER_BSLASH:
            begin
                if (c == CH_U)
                begin
                    if (it.final_byte)
                    begin
                        emit_utf8(16'h0000);
                        done = 1'b1;
                    end
                    else
                    begin
                        parse_state = IN_HEX;
                        hex_digits = 2'd0;
                        code_acc = 16'h0000;
                    end
                end
                else
                begin
                    case (c)
                        CH_N:    mapped = CH_LF;
                        CH_R:    mapped = CH_CR;
                        CH_T:    mapped = CH_TAB;
                        default: mapped = c;
                    endcase
                    emit(mapped, KIND_DATA);
                    parse_state = IN_TEXT;
                    done = it.final_byte;
                end
            end
            default:
            begin
                code_acc = {code_acc[11:0], nibble_of(c)};
                if (hex_digits == 2'd3 || it.final_byte)
                begin
                    emit_utf8(code_acc);
                    hex_digits = 2'd0;
                    code_acc = 16'h0000;
                    parse_state = IN_TEXT;
                    done = it.final_byte;
                end
                else
                begin
                    hex_digits = hex_digits + 2'd1;
                end
            end
        endcase
        if (done)
        begin
            emit(8'h00, KIND_END);
            parse_state = AWAIT_QUOTE;
            hex_digits = 2'd0;
            code_acc = 16'h0000;
        end
        if (step_n > 0)
            step_out[step_n - 1].run_last = 1'b1;
        for (int i = 0; i < step_n; i++)
            expected_results.push_back(step_out[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        logic      bad;
        if (!rst_n)
        begin
            parse_state = AWAIT_QUOTE;
            hex_digits = 2'd0;
            code_acc = 16'h0000;
            expected_results.delete();
            mismatches = 0;
            outstanding = 0;
            results_seen = 0;
        end
        else
        begin
            if (rx_valid && rx_ready)
                decode_source_byte(rx_data);
            if (tx_valid && tx_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: out_byte %h kind %0d run_last %b",
                           tx_data.out_byte, tx_data.kind, tx_data.run_last);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    bad = 1'b0;
                    if (tx_data.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, got %h", want.out_byte,
                               tx_data.out_byte);
                        bad = 1'b1;
                    end
                    if (tx_data.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, tx_data.kind);
                        bad = 1'b1;
                    end
                    if (tx_data.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %b, got %b", want.run_last,
                               tx_data.run_last);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatches++;
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives JSON source text into the unescape unit with random gaps on the
// input and random stalls on the output, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import jsu_pkg::*;

    localparam int RANDOM_ITEMS = 330;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int DRAIN_CYCLES = 64;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;

    logic clk = 1'b0;
    logic rst_n;

    jsu_stream_if #(.T(in_item_t))  rx_ch ();
    jsu_stream_if #(.T(out_item_t)) tx_ch ();

    int mismatches;
    int outstanding;
    int results_seen;

    json_string_unescape_utf8_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch)
    );

    jsu_unescape_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_ch.valid),
        .rx_ready     (rx_ch.ready),
        .rx_data      (rx_ch.data),
        .tx_valid     (tx_ch.valid),
        .tx_ready     (tx_ch.ready),
        .tx_data      (tx_ch.data),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    int  cycles = 0;
    int  bytes_sent = 0;
    int  strings_sent = 0;
    int  noise_runs = 0;
    bit  steady = 1'b0;
    in_item_t source_text [$];

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still due", cycles, outstanding);
            $display("Test completed with failures");
            $finish;
        end
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic void add_byte(logic [7:0] b, logic fin);
        source_text.push_back(in_item_t'{in_byte: b, final_byte: fin});
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10)
            return CH_DIG0 + {4'h0, v};
        if ($urandom_range(0, 1) == 0)
            return CH_LOW_A + {4'h0, v} - 8'd10;
        return CH_UP_A + {4'h0, v} - 8'd10;
    endfunction

    task automatic send_text();
        int g;
        foreach (source_text[i])
        begin
            g = gap_len();
            if (g > 0)
            begin
                rx_ch.valid <= 1'b0;
                repeat (g) @(posedge clk);
            end
            rx_ch.valid <= 1'b1;
            rx_ch.data <= source_text[i];
            do @(posedge clk); while (!rx_ch.ready);
            bytes_sent++;
        end
        source_text.delete();
    endtask

    initial
    begin
        int g;
        while (!rst_n)
            @(posedge clk);
        tx_ch.ready <= 1'b0;
        forever
        begin
            g = gap_len();
            if (g > 0)
            begin
                tx_ch.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            tx_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial
    begin
        int         tokens;
        int         r;
        int         pos;
        int         target;
        logic [7:0] b;
        logic [15:0] cp;
        in_item_t   tmp;
        logic [7:0] esc_pick [7];

        rst_n = 1'b0;
        rx_ch.valid <= 1'b0;
        rx_ch.data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // missing opening quote, empty string closed by a final quote
        add_byte(8'h78, 1'b0);
        add_byte(CH_QUOTE, 1'b1);
        // byte extremes and simple escapes inside a quoted string
        add_byte(CH_QUOTE, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(CH_BSLASH, 1'b0);
        add_byte(CH_N, 1'b0);
        add_byte(CH_BSLASH, 1'b0);
        add_byte(CH_T, 1'b0);
        add_byte(CH_BSLASH, 1'b0);
        add_byte(CH_QUOTE, 1'b0);
        add_byte(CH_QUOTE, 1'b0);
        // three-byte code point, then a final byte cutting off a hex run
        add_byte(CH_QUOTE, 1'b0);
        add_byte(CH_BSLASH, 1'b0);
        add_byte(CH_U, 1'b0);
        add_byte(8'h46, 1'b0);
        add_byte(8'h66, 1'b0);
        add_byte(8'h46, 1'b0);
        add_byte(8'h66, 1'b0);
        add_byte(CH_BSLASH, 1'b0);
        add_byte(CH_U, 1'b0);
        add_byte(8'h7A, 1'b0);
        add_byte(8'h37, 1'b1);
        // backslash as the final byte
        add_byte(CH_QUOTE, 1'b0);
        add_byte(CH_BSLASH, 1'b1);
        // final byte is the u of an escape
        add_byte(CH_QUOTE, 1'b0);
        add_byte(CH_BSLASH, 1'b0);
        add_byte(CH_U, 1'b1);
        send_text();

        esc_pick[0] = CH_QUOTE;
        esc_pick[1] = CH_BSLASH;
        esc_pick[2] = CH_SLASH;
        esc_pick[3] = CH_N;
        esc_pick[4] = CH_R;
        esc_pick[5] = CH_T;
        esc_pick[6] = 8'h00;

        target = bytes_sent + RANDOM_ITEMS;
        while (bytes_sent < target)
        begin
            steady = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 99) < 12)
            begin
                noise_runs++;
                repeat ($urandom_range(1, 3))
                    add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
            else
            begin
                strings_sent++;
                add_byte(CH_QUOTE, 1'b0);
                tokens = $urandom_range(0, 8);
                repeat (tokens)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 45)
                    begin
                        b = 8'($urandom_range(0, 255));
                        if (b == CH_QUOTE || b == CH_BSLASH)
                            b = b ^ 8'h01;
                        add_byte(b, 1'b0);
                    end
                    else if (r < 75)
                    begin
                        add_byte(CH_BSLASH, 1'b0);
                        b = esc_pick[$urandom_range(0, 6)];
                        if (b == 8'h00)
                            b = 8'($urandom_range(0, 255));
                        if (b == CH_U)
                            b = CH_N;
                        add_byte(b, 1'b0);
                    end
                    else
                    begin
                        add_byte(CH_BSLASH, 1'b0);
                        add_byte(CH_U, 1'b0);
                        r = $urandom_range(0, 99);
                        if (r < 33)
                            cp = 16'($urandom_range(0, 16'h007F));
                        else if (r < 66)
                            cp = 16'($urandom_range(16'h0080, 16'h07FF));
                        else
                            cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                        for (int d = 3; d >= 0; d--)
                        begin
                            if ($urandom_range(0, 99) < 8)
                                add_byte(8'($urandom_range(0, 255)), 1'b0);
                            else
                                add_byte(hex_char(cp[d*4 +: 4]), 1'b0);
                        end
                    end
                end
                if ($urandom_range(0, 99) < 70)
                begin
                    add_byte(CH_QUOTE, $urandom_range(0, 4) == 0);
                end
                else
                begin
                    // truncated source: final byte lands anywhere in the string
                    pos = (source_text.size() > 1) ?
                          $urandom_range(1, source_text.size() - 1) : 0;
                    while (source_text.size() > pos + 1)
                        void'(source_text.pop_back());
                    tmp = source_text[pos];
                    tmp.final_byte = 1'b1;
                    source_text[pos] = tmp;
                end
            end
            send_text();
        end
        rx_ch.valid <= 1'b0;
        @(posedge clk);

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d source bytes in %0d random strings and %0d noise runs",
                 bytes_sent, strings_sent, noise_runs);
        $display("Summary: %0d results checked, %0d mismatching", results_seen, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
